>>> rtl/inverted_frame_table_fifo_top_defines.svh
// assertion macros shared by the frame table checker
// depends on a clk and rst_n in the scope of use
`ifndef INVERTED_FRAME_TABLE_FIFO_TOP_DEFINES_SVH
`define INVERTED_FRAME_TABLE_FIFO_TOP_DEFINES_SVH

// same-cycle implication
`define IFT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define IFT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/ift_pkg.sv
// types, constants and sequencer states of the inverted frame table
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package ift_pkg;

  localparam int NFRAMES    = 64;
  localparam int NPIDS      = 64;
  localparam int FIDX_W     = 6;
  localparam int PID_W      = 6;
  localparam int PAGE_W     = 20;
  localparam int CNT_W      = 7;
  localparam int ADDR_W     = 32;
  localparam int PAGE_SHIFT = 12;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  localparam int FL_VALID  = 0;
  localparam int FL_CHAIN  = 1;
  localparam int FL_KERNEL = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_MEMORY_BASE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_LIMIT = 1'd1;
  localparam logic [PAGE_W-1:0]    KERNEL_LIMIT_RST = 20'd524288;

  typedef enum logic [1:0] {
    FN_LOOKUP  = 2'd0,
    FN_INSERT  = 2'd1,
    FN_REMOVE  = 2'd2,
    FN_RELEASE = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_MISS    = 2'd1,
    ST_NOFRAME = 2'd2
  } status_t;

  typedef struct packed {
    logic [PAGE_W-1:0] page;
    logic [PID_W-1:0]  owner;
    logic [FIDX_W-1:0] link;
    logic [2:0]        flags;
  } frame_t;

  typedef struct packed {
    logic [FIDX_W-1:0] head;
    logic [FIDX_W-1:0] tail;
    logic [CNT_W-1:0]  count;
  } proc_t;

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_DONE,
    S_LK_RDP, S_LK_P, S_LK_RDF, S_LK_F,
    S_IN_RDF, S_IN_F, S_VS_RDL, S_VS_L, S_VS_F,
    S_AL_WF, S_AL_P, S_AL_T, S_AL_LO,
    S_RM_RDF, S_RM_F,
    S_RL_RDP, S_RL_P, S_RL_CHK, S_RL_F,
    S_DR_RDF, S_DR_F, S_DR_P, S_DR_WRDF, S_DR_WF,
    S_DR_FREE, S_DR_FE, S_DR_FT, S_DR_CLR
  } state_t;

endpackage
`default_nettype wire

>>> rtl/ift_if.sv
// handshake channels of the inverted frame table: request, result, register write
// depends on ift_pkg
`timescale 1ns / 1ps
`default_nettype none
interface ift_in_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   func;
  logic [ift_pkg::PID_W-1:0]    pid;
  logic [ift_pkg::PAGE_W-1:0]   page_number;
  logic [ift_pkg::FIDX_W-1:0]   frame_select;
  modport source (output valid, func, pid, page_number, frame_select, input ready);
  modport sink (input valid, func, pid, page_number, frame_select, output ready);
endinterface

interface ift_out_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   status;
  logic [ift_pkg::FIDX_W-1:0]   frame_index;
  logic [ift_pkg::ADDR_W-1:0]   phys_address;
  logic                         evicted;
  logic [ift_pkg::PAGE_W-1:0]   evicted_page;
  logic [ift_pkg::PID_W-1:0]    evicted_pid;
  modport source (output valid, status, frame_index, phys_address, evicted, evicted_page,
                  evicted_pid, input ready);
  modport sink (input valid, status, frame_index, phys_address, evicted, evicted_page,
                evicted_pid, output ready);
endinterface

interface ift_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [ift_pkg::CFG_IDX_W-1:0]    index;
  logic [ift_pkg::CFG_DATA_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> rtl/inverted_frame_table_fifo_top.sv
// inverted frame table with free chain, per-pid chains and fifo replacement
// depends on ift_pkg, ift_if and ift_ram
//
//  channel | dir | words
//  in_ch   | in  | func, pid, page_number, frame_select
//  out_ch  | out | status, frame_index, phys_address, evicted, evicted_page, evicted_pid
//  cfg_ch  | in  | index, data (always ready)
//
// after reset a clearing pass fills the frame and pid tables
// a lookup reads the pid entry, then walks its chain from the head until the page matches
// an insert takes the free chain head, else searches the load order for a non-kernel victim
// dropping a frame unlinks it from its owner chain and puts it on the free chain; a full
// insert first evicts its victim, and a release drops the frames of the pid one by one
// a finished word waits in the output register; in_ch is ready only when idle
`timescale 1ns / 1ps
`default_nettype none
module inverted_frame_table_fifo_top (
  input wire logic   clk,
  input wire logic   rst_n,
  ift_in_if.sink     in_ch,
  ift_out_if.source  out_ch,
  ift_cfg_if.sink    cfg_ch
);
  localparam int FW = $bits(ift_pkg::frame_t);
  localparam int PW = $bits(ift_pkg::proc_t);
  localparam int FN = ift_pkg::FIDX_W;
  localparam int CW = ift_pkg::CNT_W;

  ift_pkg::state_t state_r, state_nxt;
  ift_pkg::func_t  func_r, func_nxt;
  logic [ift_pkg::PID_W-1:0]  pid_r, pid_nxt;
  logic [ift_pkg::PAGE_W-1:0] page_r, page_nxt;
  logic [FN-1:0] sel_r, sel_nxt;
  logic [FN-1:0] free_head_r, free_head_nxt, free_tail_r, free_tail_nxt;
  logic [FN-1:0] owp_r, owp_nxt, orp_r, orp_nxt;
  logic [ift_pkg::ADDR_W-1:0] base_r, base_nxt;
  logic [ift_pkg::PAGE_W-1:0] kpl_r, kpl_nxt;
  logic [FN-1:0] idx_r, idx_nxt, rp_r, rp_nxt, f_r, f_nxt, df_r, df_nxt;
  logic [FN-1:0] rel_i_r, rel_i_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt, rel_k_r, rel_k_nxt, rel_n_r, rel_n_nxt;
  ift_pkg::frame_t fw_r, fw_nxt;
  ift_pkg::proc_t  pw_r, pw_nxt;
  logic [1:0] res_status_r, res_status_nxt;
  logic [FN-1:0] res_frame_r, res_frame_nxt;
  logic res_hasf_r, res_hasf_nxt, res_ev_r, res_ev_nxt;
  logic [ift_pkg::PAGE_W-1:0] res_evpage_r, res_evpage_nxt;
  logic [ift_pkg::PID_W-1:0]  res_evpid_r, res_evpid_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [1:0] out_status_r, out_status_nxt;
  logic [FN-1:0] out_frame_r, out_frame_nxt;
  logic [ift_pkg::ADDR_W-1:0] out_addr_r, out_addr_nxt;
  logic out_ev_r, out_ev_nxt;
  logic [ift_pkg::PAGE_W-1:0] out_evpage_r, out_evpage_nxt;
  logic [ift_pkg::PID_W-1:0]  out_evpid_r, out_evpid_nxt;

  logic fr_we, pr_we, lo_we;
  logic [FN-1:0] fr_waddr, fr_raddr, pr_waddr, pr_raddr, lo_waddr, lo_raddr;
  ift_pkg::frame_t fr_wdata, frd;
  ift_pkg::proc_t  pr_wdata, prd;
  logic [FW-1:0] fr_rdata;
  logic [PW-1:0] pr_rdata;
  logic [FN-1:0] lo_wdata, lo_rdata;
  logic in_acc;

  ift_ram #(.WIDTH(FW), .DEPTH(ift_pkg::NFRAMES)) u_frame_ram (
    .clk(clk), .we(fr_we), .waddr(fr_waddr), .wdata(fr_wdata),
    .raddr(fr_raddr), .rdata(fr_rdata));
  ift_ram #(.WIDTH(PW), .DEPTH(ift_pkg::NPIDS)) u_proc_ram (
    .clk(clk), .we(pr_we), .waddr(pr_waddr), .wdata(pr_wdata),
    .raddr(pr_raddr), .rdata(pr_rdata));
  ift_ram #(.WIDTH(FN), .DEPTH(ift_pkg::NFRAMES)) u_order_ram (
    .clk(clk), .we(lo_we), .waddr(lo_waddr), .wdata(lo_wdata),
    .raddr(lo_raddr), .rdata(lo_rdata));

  assign frd = ift_pkg::frame_t'(fr_rdata);
  assign prd = ift_pkg::proc_t'(pr_rdata);

  assign in_ch.ready  = (state_r == ift_pkg::S_IDLE);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.frame_index  = out_frame_r;
  assign out_ch.phys_address = out_addr_r;
  assign out_ch.evicted      = out_ev_r;
  assign out_ch.evicted_page = out_evpage_r;
  assign out_ch.evicted_pid  = out_evpid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ift_pkg::S_INIT;
      free_head_r <= '0;
      free_tail_r <= FN'(ift_pkg::NFRAMES - 1);
      owp_r       <= '0;
      orp_r       <= FN'(ift_pkg::NFRAMES - 1);
      base_r      <= '0;
      kpl_r       <= ift_pkg::KERNEL_LIMIT_RST;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      free_head_r <= free_head_nxt;
      free_tail_r <= free_tail_nxt;
      owp_r       <= owp_nxt;
      orp_r       <= orp_nxt;
      base_r      <= base_nxt;
      kpl_r       <= kpl_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r       <= func_nxt;
    pid_r        <= pid_nxt;
    page_r       <= page_nxt;
    sel_r        <= sel_nxt;
    rp_r         <= rp_nxt;
    f_r          <= f_nxt;
    df_r         <= df_nxt;
    rel_i_r      <= rel_i_nxt;
    cnt_r        <= cnt_nxt;
    rel_k_r      <= rel_k_nxt;
    rel_n_r      <= rel_n_nxt;
    fw_r         <= fw_nxt;
    pw_r         <= pw_nxt;
    res_status_r <= res_status_nxt;
    res_frame_r  <= res_frame_nxt;
    res_hasf_r   <= res_hasf_nxt;
    res_ev_r     <= res_ev_nxt;
    res_evpage_r <= res_evpage_nxt;
    res_evpid_r  <= res_evpid_nxt;
    out_status_r <= out_status_nxt;
    out_frame_r  <= out_frame_nxt;
    out_addr_r   <= out_addr_nxt;
    out_ev_r     <= out_ev_nxt;
    out_evpage_r <= out_evpage_nxt;
    out_evpid_r  <= out_evpid_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    func_nxt       = func_r;
    pid_nxt        = pid_r;
    page_nxt       = page_r;
    sel_nxt        = sel_r;
    free_head_nxt  = free_head_r;
    free_tail_nxt  = free_tail_r;
    owp_nxt        = owp_r;
    orp_nxt        = orp_r;
    base_nxt       = base_r;
    kpl_nxt        = kpl_r;
    idx_nxt        = idx_r;
    rp_nxt         = rp_r;
    f_nxt          = f_r;
    df_nxt         = df_r;
    rel_i_nxt      = rel_i_r;
    cnt_nxt        = cnt_r;
    rel_k_nxt      = rel_k_r;
    rel_n_nxt      = rel_n_r;
    fw_nxt         = fw_r;
    pw_nxt         = pw_r;
    res_status_nxt = res_status_r;
    res_frame_nxt  = res_frame_r;
    res_hasf_nxt   = res_hasf_r;
    res_ev_nxt     = res_ev_r;
    res_evpage_nxt = res_evpage_r;
    res_evpid_nxt  = res_evpid_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_frame_nxt  = out_frame_r;
    out_addr_nxt   = out_addr_r;
    out_ev_nxt     = out_ev_r;
    out_evpage_nxt = out_evpage_r;
    out_evpid_nxt  = out_evpid_r;
    fr_we    = 1'b0;
    fr_waddr = df_r;
    fr_wdata = '0;
    fr_raddr = idx_r;
    pr_we    = 1'b0;
    pr_waddr = pid_r;
    pr_wdata = '0;
    pr_raddr = pid_r;
    lo_we    = 1'b0;
    lo_waddr = owp_r;
    lo_wdata = f_r;
    lo_raddr = rp_r;

    if (cfg_ch.valid) begin
      if (cfg_ch.index == ift_pkg::CFG_MEMORY_BASE) begin
        base_nxt = cfg_ch.data;
      end else begin
        kpl_nxt = cfg_ch.data[ift_pkg::PAGE_W-1:0];
      end
    end
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ift_pkg::S_INIT: begin
        fr_we    = 1'b1;
        fr_waddr = idx_r;
        fr_wdata.link = idx_r + FN'(1);
        fr_wdata.flags[ift_pkg::FL_CHAIN] = (idx_r != FN'(ift_pkg::NFRAMES - 1));
        pr_we    = 1'b1;
        pr_waddr = idx_r;
        idx_nxt  = idx_r + FN'(1);
        if (idx_r == FN'(ift_pkg::NFRAMES - 1)) begin
          state_nxt = ift_pkg::S_IDLE;
        end
      end
      ift_pkg::S_IDLE: begin
        if (in_acc) begin
          func_nxt       = ift_pkg::func_t'(in_ch.func);
          pid_nxt        = in_ch.pid;
          page_nxt       = in_ch.page_number;
          sel_nxt        = in_ch.frame_select;
          res_status_nxt = ift_pkg::ST_DONE;
          res_frame_nxt  = '0;
          res_hasf_nxt   = 1'b0;
          res_ev_nxt     = 1'b0;
          res_evpage_nxt = '0;
          res_evpid_nxt  = '0;
          unique case (ift_pkg::func_t'(in_ch.func))
            ift_pkg::FN_LOOKUP: state_nxt = ift_pkg::S_LK_RDP;
            ift_pkg::FN_INSERT: state_nxt = ift_pkg::S_IN_RDF;
            ift_pkg::FN_REMOVE: state_nxt = ift_pkg::S_RM_RDF;
            default:            state_nxt = ift_pkg::S_RL_RDP;
          endcase
        end
      end
      ift_pkg::S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_frame_nxt  = res_frame_r;
          out_addr_nxt   = res_hasf_r ?
              base_r + {{(ift_pkg::ADDR_W - FN - ift_pkg::PAGE_SHIFT){1'b0}}, res_frame_r,
                        {ift_pkg::PAGE_SHIFT{1'b0}}} : '0;
          out_ev_nxt     = res_ev_r;
          out_evpage_nxt = res_evpage_r;
          out_evpid_nxt  = res_evpid_r;
          state_nxt      = ift_pkg::S_IDLE;
        end
      end
      // lookup
      ift_pkg::S_LK_RDP: begin
        pr_raddr  = pid_r;
        state_nxt = ift_pkg::S_LK_P;
      end
      ift_pkg::S_LK_P: begin
        if (prd.count == '0) begin
          res_status_nxt = ift_pkg::ST_MISS;
          state_nxt      = ift_pkg::S_DONE;
        end else begin
          idx_nxt   = prd.head;
          cnt_nxt   = '0;
          state_nxt = ift_pkg::S_LK_RDF;
        end
      end
      ift_pkg::S_LK_RDF: begin
        fr_raddr  = idx_r;
        state_nxt = ift_pkg::S_LK_F;
      end
      ift_pkg::S_LK_F: begin
        if (frd.page == page_r) begin
          res_frame_nxt = idx_r;
          res_hasf_nxt  = 1'b1;
          state_nxt     = ift_pkg::S_DONE;
        end else if (!frd.flags[ift_pkg::FL_CHAIN] || cnt_r == CW'(ift_pkg::NFRAMES - 1)) begin
          res_status_nxt = ift_pkg::ST_MISS;
          state_nxt      = ift_pkg::S_DONE;
        end else begin
          idx_nxt   = frd.link;
          cnt_nxt   = cnt_r + CW'(1);
          state_nxt = ift_pkg::S_LK_RDF;
        end
      end
      // insert
      ift_pkg::S_IN_RDF: begin
        fr_raddr  = free_head_r;
        state_nxt = ift_pkg::S_IN_F;
      end
      ift_pkg::S_IN_F: begin
        if (!(free_head_r == free_tail_r && frd.flags[ift_pkg::FL_VALID])) begin
          f_nxt = free_head_r;
          if (free_head_r != free_tail_r) begin
            free_head_nxt = frd.link;
          end
          state_nxt = ift_pkg::S_AL_WF;
        end else begin
          rp_nxt    = orp_r;
          cnt_nxt   = '0;
          state_nxt = ift_pkg::S_VS_RDL;
        end
      end
      ift_pkg::S_VS_RDL: begin
        lo_raddr  = rp_r + FN'(1);
        rp_nxt    = rp_r + FN'(1);
        state_nxt = ift_pkg::S_VS_L;
      end
      ift_pkg::S_VS_L: begin
        fr_raddr  = lo_rdata;
        f_nxt     = lo_rdata;
        state_nxt = ift_pkg::S_VS_F;
      end
      ift_pkg::S_VS_F: begin
        if (!frd.flags[ift_pkg::FL_KERNEL]) begin
          orp_nxt        = rp_r;
          res_ev_nxt     = 1'b1;
          res_evpage_nxt = frd.page;
          res_evpid_nxt  = frd.owner;
          df_nxt         = f_r;
          state_nxt      = ift_pkg::S_DR_RDF;
        end else if (cnt_r == CW'(ift_pkg::NFRAMES - 1)) begin
          res_status_nxt = ift_pkg::ST_NOFRAME;
          state_nxt      = ift_pkg::S_DONE;
        end else begin
          cnt_nxt   = cnt_r + CW'(1);
          state_nxt = ift_pkg::S_VS_RDL;
        end
      end
      ift_pkg::S_AL_WF: begin
        fr_we    = 1'b1;
        fr_waddr = f_r;
        fr_wdata.page  = page_r;
        fr_wdata.owner = pid_r;
        fr_wdata.flags[ift_pkg::FL_VALID]  = 1'b1;
        fr_wdata.flags[ift_pkg::FL_KERNEL] = (page_r > kpl_r);
        pr_raddr  = pid_r;
        state_nxt = ift_pkg::S_AL_P;
      end
      ift_pkg::S_AL_P: begin
        pr_we          = 1'b1;
        pr_waddr       = pid_r;
        pr_wdata.head  = (prd.count == '0) ? f_r : prd.head;
        pr_wdata.tail  = f_r;
        pr_wdata.count = prd.count + CW'(1);
        fr_raddr       = prd.tail;
        idx_nxt        = prd.tail;
        state_nxt      = (prd.count == '0) ? ift_pkg::S_AL_LO : ift_pkg::S_AL_T;
      end
      ift_pkg::S_AL_T: begin
        fr_we    = 1'b1;
        fr_waddr = idx_r;
        fr_wdata = frd;
        fr_wdata.flags[ift_pkg::FL_CHAIN] = 1'b1;
        fr_wdata.link = f_r;
        state_nxt = ift_pkg::S_AL_LO;
      end
      ift_pkg::S_AL_LO: begin
        lo_we         = 1'b1;
        lo_waddr      = owp_r;
        lo_wdata      = f_r;
        owp_nxt       = owp_r + FN'(1);
        res_frame_nxt = f_r;
        res_hasf_nxt  = 1'b1;
        state_nxt     = ift_pkg::S_DONE;
      end
      // remove
      ift_pkg::S_RM_RDF: begin
        fr_raddr  = sel_r;
        state_nxt = ift_pkg::S_RM_F;
      end
      ift_pkg::S_RM_F: begin
        if (frd.flags[ift_pkg::FL_VALID]) begin
          df_nxt    = sel_r;
          state_nxt = ift_pkg::S_DR_RDF;
        end else begin
          res_status_nxt = ift_pkg::ST_MISS;
          state_nxt      = ift_pkg::S_DONE;
        end
      end
      // release
      ift_pkg::S_RL_RDP: begin
        pr_raddr  = pid_r;
        state_nxt = ift_pkg::S_RL_P;
      end
      ift_pkg::S_RL_P: begin
        rel_n_nxt = prd.count;
        rel_i_nxt = prd.head;
        rel_k_nxt = '0;
        state_nxt = ift_pkg::S_RL_CHK;
      end
      ift_pkg::S_RL_CHK: begin
        fr_raddr  = rel_i_r;
        state_nxt = (rel_k_r == rel_n_r) ? ift_pkg::S_DONE : ift_pkg::S_RL_F;
      end
      ift_pkg::S_RL_F: begin
        if (!frd.flags[ift_pkg::FL_VALID] || frd.owner != pid_r) begin
          state_nxt = ift_pkg::S_DONE;
        end else begin
          df_nxt    = rel_i_r;
          rel_i_nxt = frd.link;
          rel_k_nxt = rel_k_r + CW'(1);
          state_nxt = ift_pkg::S_DR_RDF;
        end
      end
      // drop one frame
      ift_pkg::S_DR_RDF: begin
        fr_raddr  = df_r;
        state_nxt = ift_pkg::S_DR_F;
      end
      ift_pkg::S_DR_F: begin
        fw_nxt    = frd;
        pr_raddr  = frd.owner;
        state_nxt = ift_pkg::S_DR_P;
      end
      ift_pkg::S_DR_P: begin
        pw_nxt   = prd;
        pr_waddr = fw_r.owner;
        pr_wdata = prd;
        pr_wdata.count = prd.count - CW'(1);
        state_nxt = ift_pkg::S_DR_FREE;
        if (prd.count == CW'(1)) begin
          pr_we         = 1'b1;
          pr_wdata.tail = prd.head;
        end else if (prd.count != '0) begin
          if (prd.head == df_r) begin
            pr_we         = 1'b1;
            pr_wdata.head = fw_r.link;
          end else begin
            idx_nxt   = prd.head;
            cnt_nxt   = '0;
            state_nxt = ift_pkg::S_DR_WRDF;
          end
        end
      end
      ift_pkg::S_DR_WRDF: begin
        fr_raddr  = idx_r;
        state_nxt = ift_pkg::S_DR_WF;
      end
      ift_pkg::S_DR_WF: begin
        if (frd.flags[ift_pkg::FL_CHAIN] && frd.link != df_r &&
            cnt_r < CW'(ift_pkg::NFRAMES)) begin
          idx_nxt   = frd.link;
          cnt_nxt   = cnt_r + CW'(1);
          state_nxt = ift_pkg::S_DR_WRDF;
        end else begin
          pr_we    = 1'b1;
          pr_waddr = fw_r.owner;
          pr_wdata = pw_r;
          pr_wdata.count = pw_r.count - CW'(1);
          fr_waddr = idx_r;
          fr_wdata = frd;
          if (frd.flags[ift_pkg::FL_CHAIN] && frd.link == df_r) begin
            fr_we = 1'b1;
            if (df_r == pw_r.tail) begin
              pr_wdata.tail = idx_r;
              fr_wdata.flags[ift_pkg::FL_CHAIN] = 1'b0;
            end else begin
              fr_wdata.link = fw_r.link;
            end
          end
          state_nxt = ift_pkg::S_DR_FREE;
        end
      end
      ift_pkg::S_DR_FREE: begin
        fr_raddr  = free_head_r;
        state_nxt = ift_pkg::S_DR_FE;
      end
      ift_pkg::S_DR_FE: begin
        if (free_head_r == free_tail_r && frd.flags[ift_pkg::FL_VALID]) begin
          free_head_nxt = df_r;
          free_tail_nxt = df_r;
          state_nxt     = ift_pkg::S_DR_CLR;
        end else begin
          fr_raddr  = free_tail_r;
          state_nxt = ift_pkg::S_DR_FT;
        end
      end
      ift_pkg::S_DR_FT: begin
        fr_we    = 1'b1;
        fr_waddr = free_tail_r;
        fr_wdata = frd;
        fr_wdata.flags[ift_pkg::FL_CHAIN] = 1'b1;
        fr_wdata.link = df_r;
        free_tail_nxt = df_r;
        state_nxt     = ift_pkg::S_DR_CLR;
      end
      ift_pkg::S_DR_CLR: begin
        fr_we    = 1'b1;
        fr_waddr = df_r;
        fr_wdata = '0;
        unique case (func_r)
          ift_pkg::FN_INSERT: state_nxt = ift_pkg::S_AL_WF;
          ift_pkg::FN_RELEASE: state_nxt = ift_pkg::S_RL_CHK;
          default: begin
            res_frame_nxt = df_r;
            res_hasf_nxt  = 1'b1;
            state_nxt     = ift_pkg::S_DONE;
          end
        endcase
      end
      default: state_nxt = ift_pkg::S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

>>> rtl/ift_ram.sv
// generic single write port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module ift_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> rtl/ift_checker.sv
// port-level checks on the frame table top level, bound to it below
// depends on inverted_frame_table_fifo_top_defines.svh and ift_pkg
`timescale 1ns / 1ps
`default_nettype none
`include "inverted_frame_table_fifo_top_defines.svh"
module ift_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_valid,
  input wire logic                        in_ready,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [1:0]                  out_status,
  input wire logic [ift_pkg::FIDX_W-1:0]  out_frame_index,
  input wire logic                        out_evicted
);
  `IFT_ASSERT_NOW(a_status_code, out_valid, out_status != 2'd3, "bad status code")
  `IFT_ASSERT_NOW(a_evict_ok, out_valid && out_evicted, out_status == ift_pkg::ST_DONE, "evict without success")
  `IFT_ASSERT_NOW(a_fail_frame, out_valid && out_status != ift_pkg::ST_DONE, out_frame_index == '0, "frame on failure")
  `IFT_ASSERT_NXT(a_busy, in_valid && in_ready, !in_ready, "ready right after accept")
  `IFT_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
endmodule

bind inverted_frame_table_fifo_top ift_checker u_ift_checker (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_status(out_ch.status), .out_frame_index(out_ch.frame_index),
  .out_evicted(out_ch.evicted)
);
`default_nettype wire

>>> test/inverted_frame_table_fifo_top_test.sv
// self-checking testbench of the inverted frame table with fifo replacement
// depends on ift_pkg, ift_if and the inverted_frame_table_fifo_top rtl
// predicts every result word in a scoreboard class, drives requests with random idling
`timescale 1ns / 1ps
module inverted_frame_table_fifo_top_test;

  localparam int CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic [1:0]                 status;
    logic [ift_pkg::FIDX_W-1:0] frame_index;
    logic [ift_pkg::ADDR_W-1:0] phys_address;
    logic                       evicted;
    logic [ift_pkg::PAGE_W-1:0] evicted_page;
    logic [ift_pkg::PID_W-1:0]  evicted_pid;
  } result_t;

  class frame_table_scoreboard;
    logic [ift_pkg::PAGE_W-1:0] fpage[ift_pkg::NFRAMES];
    logic [ift_pkg::PID_W-1:0]  fowner[ift_pkg::NFRAMES];
    logic [ift_pkg::FIDX_W-1:0] flink[ift_pkg::NFRAMES];
    logic [2:0]                 fflags[ift_pkg::NFRAMES];
    logic [ift_pkg::FIDX_W-1:0] free_hd, free_tl;
    logic [ift_pkg::FIDX_W-1:0] pid_hd[ift_pkg::NPIDS], pid_tl[ift_pkg::NPIDS];
    int                         pid_cnt[ift_pkg::NPIDS];
    logic [ift_pkg::FIDX_W-1:0] loaded[ift_pkg::NFRAMES];
    logic [ift_pkg::FIDX_W-1:0] load_wr, load_rd;
    logic [ift_pkg::ADDR_W-1:0] mem_base;
    logic [ift_pkg::PAGE_W-1:0] kern_limit;
    result_t                    expected_words[$];
    int                         errors;

    function new();
      for (int i = 0; i < ift_pkg::NFRAMES; i++) begin
        fpage[i] = '0;
        fowner[i] = '0;
        flink[i] = ift_pkg::FIDX_W'(i + 1);
        fflags[i] = '0;
        fflags[i][ift_pkg::FL_CHAIN] = (i != ift_pkg::NFRAMES - 1);
        loaded[i] = '0;
      end
      for (int p = 0; p < ift_pkg::NPIDS; p++) begin
        pid_hd[p] = '0;
        pid_tl[p] = '0;
        pid_cnt[p] = 0;
      end
      free_hd = '0;
      free_tl = ift_pkg::FIDX_W'(ift_pkg::NFRAMES - 1);
      load_wr = '0;
      load_rd = ift_pkg::FIDX_W'(ift_pkg::NFRAMES - 1);
      mem_base = '0;
      kern_limit = ift_pkg::KERNEL_LIMIT_RST;
      errors = 0;
    endfunction

    function void write_reg(logic [ift_pkg::CFG_IDX_W-1:0] idx,
                            logic [ift_pkg::CFG_DATA_W-1:0] val);
      if (idx == ift_pkg::CFG_MEMORY_BASE) mem_base = val;
      else kern_limit = val[ift_pkg::PAGE_W-1:0];
    endfunction

    function bit free_empty();
      return free_hd == free_tl && fflags[free_hd][ift_pkg::FL_VALID];
    endfunction

    function logic [ift_pkg::ADDR_W-1:0] frame_addr(logic [ift_pkg::FIDX_W-1:0] f);
      return mem_base + (ift_pkg::ADDR_W'(f) << ift_pkg::PAGE_SHIFT);
    endfunction

    function void free_frame(logic [ift_pkg::FIDX_W-1:0] f);
      logic [ift_pkg::PID_W-1:0]  p;
      logic [ift_pkg::FIDX_W-1:0] i;
      int                         n;
      p = fowner[f];
      if (pid_cnt[p] > 0) begin
        if (pid_cnt[p] != 1) begin
          if (pid_hd[p] == f) begin
            pid_hd[p] = flink[f];
          end else begin
            i = pid_hd[p];
            n = 0;
            while (fflags[i][ift_pkg::FL_CHAIN] && flink[i] != f && n < ift_pkg::NFRAMES) begin
              i = flink[i];
              n++;
            end
            if (fflags[i][ift_pkg::FL_CHAIN] && flink[i] == f) begin
              if (f == pid_tl[p]) begin
                pid_tl[p] = i;
                fflags[i][ift_pkg::FL_CHAIN] = 1'b0;
              end else begin
                flink[i] = flink[f];
              end
            end
          end
        end else begin
          pid_tl[p] = pid_hd[p];
        end
        pid_cnt[p]--;
      end
      if (free_empty()) begin
        free_hd = f;
        free_tl = f;
      end else begin
        fflags[free_tl][ift_pkg::FL_CHAIN] = 1'b1;
        flink[free_tl] = f;
        free_tl = f;
      end
      fflags[f] = '0;
      fpage[f] = '0;
      fowner[f] = '0;
      flink[f] = '0;
    endfunction

    function void note_request(ift_pkg::func_t fn, logic [ift_pkg::PID_W-1:0] pid,
                               logic [ift_pkg::PAGE_W-1:0] page,
                               logic [ift_pkg::FIDX_W-1:0] sel);
      result_t                    r;
      logic [ift_pkg::FIDX_W-1:0] i, f, rp, nxt;
      bit                         ok;
      int                         n;
      r = '0;
      case (fn)
        ift_pkg::FN_LOOKUP: begin
          r.status = ift_pkg::ST_MISS;
          if (pid_cnt[pid] > 0) begin
            i = pid_hd[pid];
            for (n = 0; n < ift_pkg::NFRAMES; n++) begin
              if (fpage[i] == page) begin
                r.status = ift_pkg::ST_DONE;
                r.frame_index = i;
                r.phys_address = frame_addr(i);
                break;
              end
              if (!fflags[i][ift_pkg::FL_CHAIN]) break;
              i = flink[i];
            end
          end
        end
        ift_pkg::FN_INSERT: begin
          ok = 0;
          f = '0;
          if (!free_empty()) begin
            f = free_hd;
            if (free_hd != free_tl) free_hd = flink[free_hd];
            ok = 1;
          end else begin
            rp = load_rd;
            for (n = 0; n < ift_pkg::NFRAMES; n++) begin
              rp = rp + 1'b1;
              f = loaded[rp];
              if (!fflags[f][ift_pkg::FL_KERNEL]) begin
                ok = 1;
                break;
              end
            end
            if (ok) begin
              load_rd = rp;
              r.evicted = 1'b1;
              r.evicted_page = fpage[f];
              r.evicted_pid = fowner[f];
              free_frame(f);
            end
          end
          if (ok) begin
            fflags[f] = '0;
            fflags[f][ift_pkg::FL_VALID] = 1'b1;
            fflags[f][ift_pkg::FL_KERNEL] = page > kern_limit;
            fpage[f] = page;
            fowner[f] = pid;
            flink[f] = '0;
            if (pid_cnt[pid] == 0) begin
              pid_hd[pid] = f;
            end else begin
              fflags[pid_tl[pid]][ift_pkg::FL_CHAIN] = 1'b1;
              flink[pid_tl[pid]] = f;
            end
            pid_tl[pid] = f;
            pid_cnt[pid]++;
            loaded[load_wr] = f;
            load_wr = load_wr + 1'b1;
            r.frame_index = f;
            r.phys_address = frame_addr(f);
          end else begin
            r.status = ift_pkg::ST_NOFRAME;
          end
        end
        ift_pkg::FN_REMOVE: begin
          if (fflags[sel][ift_pkg::FL_VALID]) begin
            free_frame(sel);
            r.frame_index = sel;
            r.phys_address = frame_addr(sel);
          end else begin
            r.status = ift_pkg::ST_MISS;
          end
        end
        default: begin
          i = pid_hd[pid];
          n = pid_cnt[pid];
          for (int k = 0; k < n; k++) begin
            if (!fflags[i][ift_pkg::FL_VALID] || fowner[i] != pid) break;
            nxt = flink[i];
            free_frame(i);
            i = nxt;
          end
        end
      endcase
      expected_words.push_back(r);
    endfunction

    function void check_word(result_t got);
      result_t e;
      if (expected_words.size() == 0) begin
        $error("result word with none expected");
        errors++;
        return;
      end
      e = expected_words.pop_front();
      if (got.status !== e.status) begin
        $error("status exp %0d got %0d", e.status, got.status);
        errors++;
      end
      if (got.frame_index !== e.frame_index) begin
        $error("frame_index exp %0d got %0d", e.frame_index, got.frame_index);
        errors++;
      end
      if (got.phys_address !== e.phys_address) begin
        $error("phys_address exp %h got %h", e.phys_address, got.phys_address);
        errors++;
      end
      if (got.evicted !== e.evicted) begin
        $error("evicted exp %0d got %0d", e.evicted, got.evicted);
        errors++;
      end
      if (got.evicted_page !== e.evicted_page) begin
        $error("evicted_page exp %h got %h", e.evicted_page, got.evicted_page);
        errors++;
      end
      if (got.evicted_pid !== e.evicted_pid) begin
        $error("evicted_pid exp %0d got %0d", e.evicted_pid, got.evicted_pid);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   quiet;
  int   cycles;
  frame_table_scoreboard sb;

  ift_in_if  in_if();
  ift_out_if out_if();
  ift_cfg_if cfg_if();

  inverted_frame_table_fifo_top DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready)
      sb.check_word({out_if.status, out_if.frame_index, out_if.phys_address, out_if.evicted,
                     out_if.evicted_page, out_if.evicted_pid});
  end

  // result side back-pressure
  initial begin
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 9) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
      out_if.ready <= 1'b1;
    end
  end

  task automatic write_reg(logic [ift_pkg::CFG_IDX_W-1:0] idx,
                           logic [ift_pkg::CFG_DATA_W-1:0] val);
    cfg_if.index <= idx;
    cfg_if.data <= val;
    cfg_if.valid <= 1'b1;
    do @(posedge clk); while (!cfg_if.ready);
    sb.write_reg(idx, val);
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (sb.expected_words.size() != 0) @(posedge clk);
  endtask

  task automatic send(ift_pkg::func_t fn, logic [ift_pkg::PID_W-1:0] pid,
                      logic [ift_pkg::PAGE_W-1:0] page, logic [ift_pkg::FIDX_W-1:0] sel);
    in_if.func <= fn;
    in_if.pid <= pid;
    in_if.page_number <= page;
    in_if.frame_select <= sel;
    in_if.valid <= 1'b1;
    do @(posedge clk); while (!in_if.ready);
    sb.note_request(fn, pid, page, sel);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  task automatic send_random();
    ift_pkg::func_t             fn;
    logic [ift_pkg::PID_W-1:0]  pid;
    logic [ift_pkg::PAGE_W-1:0] page;
    int                         pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) fn = ift_pkg::FN_INSERT;
    else if (pick < 75) fn = ift_pkg::FN_LOOKUP;
    else if (pick < 92) fn = ift_pkg::FN_REMOVE;
    else fn = ift_pkg::FN_RELEASE;
    pid = ($urandom_range(0, 4) == 0) ? ift_pkg::PID_W'($urandom) :
                                        ift_pkg::PID_W'($urandom_range(0, 3));
    case ($urandom_range(0, 5))
      0, 1: page = ift_pkg::PAGE_W'($urandom_range(0, 15));
      2:    page = 20'h80000 + ift_pkg::PAGE_W'($urandom_range(0, 15));
      3:    page = 20'hFFFFF;
      default: page = ift_pkg::PAGE_W'($urandom);
    endcase
    send(fn, pid, page, ift_pkg::FIDX_W'($urandom));
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    quiet = 1'b0;
    cycles = 0;
    in_if.valid = 1'b0;
    in_if.func = ift_pkg::FN_LOOKUP;
    in_if.pid = '0;
    in_if.page_number = '0;
    in_if.frame_select = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = ift_pkg::CFG_MEMORY_BASE;
    cfg_if.data = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty table, chains, duplicates, kernel boundary
    write_reg(ift_pkg::CFG_KERNEL_LIMIT, 32'h80000);
    send(ift_pkg::FN_LOOKUP, 6'd0, 20'h0, 6'd0);
    send(ift_pkg::FN_REMOVE, 6'd0, 20'h0, 6'd5);
    send(ift_pkg::FN_RELEASE, 6'd7, 20'h0, 6'd0);
    send(ift_pkg::FN_INSERT, 6'd0, 20'h0, 6'd0);
    send(ift_pkg::FN_INSERT, 6'd0, 20'h0, 6'd0);
    send(ift_pkg::FN_LOOKUP, 6'd0, 20'h0, 6'd0);
    send(ift_pkg::FN_INSERT, 6'd63, 20'hFFFFF, 6'd0);
    send(ift_pkg::FN_INSERT, 6'd63, 20'h80000, 6'd0);
    send(ift_pkg::FN_INSERT, 6'd63, 20'h80001, 6'd0);
    send(ift_pkg::FN_LOOKUP, 6'd63, 20'hFFFFF, 6'd0);
    send(ift_pkg::FN_LOOKUP, 6'd63, 20'h12345, 6'd0);
    send(ift_pkg::FN_REMOVE, 6'd0, 20'h0, 6'd0);
    send(ift_pkg::FN_LOOKUP, 6'd0, 20'h0, 6'd0);
    send(ift_pkg::FN_INSERT, 6'd0, 20'h5, 6'd0);
    send(ift_pkg::FN_REMOVE, 6'd0, 20'h0, 6'd5);
    send(ift_pkg::FN_REMOVE, 6'd0, 20'h0, 6'd3);
    send(ift_pkg::FN_LOOKUP, 6'd63, 20'h80001, 6'd0);
    send(ift_pkg::FN_RELEASE, 6'd63, 20'h0, 6'd0);
    send(ift_pkg::FN_RELEASE, 6'd0, 20'h0, 6'd0);
    send(ift_pkg::FN_LOOKUP, 6'd0, 20'h0, 6'd0);
    send(ift_pkg::FN_REMOVE, 6'd0, 20'h0, 6'd63);
    in_if.valid <= 1'b0;
    drain();

    // no kernel frames, top base address wraps
    write_reg(ift_pkg::CFG_MEMORY_BASE, 32'hFFFFF000);
    write_reg(ift_pkg::CFG_KERNEL_LIMIT, 32'hFFFFF);
    repeat (50) send_random();
    in_if.valid <= 1'b0;
    drain();
    repeat (50) send_random();
    in_if.valid <= 1'b0;
    drain();

    // every insert of a nonzero page is kernel, table fills until no frame can be replaced
    write_reg(ift_pkg::CFG_MEMORY_BASE, $urandom_range(0, 32'hFFFFF000));
    write_reg(ift_pkg::CFG_KERNEL_LIMIT, 32'h0);
    repeat (110) send_random();
    in_if.valid <= 1'b0;
    drain();

    // default boundary, free everything first then mixed traffic
    write_reg(ift_pkg::CFG_MEMORY_BASE, 32'h0);
    write_reg(ift_pkg::CFG_KERNEL_LIMIT, 32'h80000);
    for (int p = 0; p < ift_pkg::NPIDS; p++)
      send(ift_pkg::FN_RELEASE, ift_pkg::PID_W'(p), 20'h0, 6'd0);
    repeat (60) send_random();
    quiet = 1'b1;
    repeat (40) send_random();
    in_if.valid <= 1'b0;
    drain();
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

>>> sim.f
+incdir+rtl
rtl/ift_pkg.sv
rtl/ift_if.sv
rtl/ift_ram.sv
rtl/inverted_frame_table_fifo_top.sv
rtl/ift_checker.sv
test/inverted_frame_table_fifo_top_test.sv
